[sv/lru_translation_buffer_assert.svh]
// Assertion macros used by the translation buffer RTL.
`ifndef LRU_TRANSLATION_BUFFER_ASSERT_SVH
`define LRU_TRANSLATION_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
`define LRUTB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LRUTB_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRUTB_ASSERT(lbl, clk, rst, prop, msg)
`define LRUTB_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

[sv/lrutb_pkg.sv]
`default_nettype none
package lrutb_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MODE_W  = 3;
  localparam int PID_W   = 16;
  localparam int VPN_W   = 20;
  localparam int FRAME_W = 20;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 32;

  localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INV      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INV_PROC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH    = 3'd4;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_MTF  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [VPN_W-1:0]   vpn;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             pid_only;
    logic [PID_W-1:0] pid;
    logic [VPN_W-1:0] vpn;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic first;
    logic seen;
  } stat_t;

endpackage
`default_nettype wire

[sv/lrutb_cell.sv]
`default_nettype none
module lrutb_cell (
  input  logic             clk,
  input  lrutb_pkg::ctl_t   ctl,
  input  logic             occupied,
  input  logic             seen_in,
  input  lrutb_pkg::entry_t prev_entry,
  input  lrutb_pkg::entry_t next_entry,
  output lrutb_pkg::entry_t entry,
  output lrutb_pkg::stat_t  stat
);
  import lrutb_pkg::*;

  logic   hit_here;
  entry_t entry_next;

  assign hit_here = occupied && (entry.pid == ctl.pid) &&
                    (ctl.pid_only || (entry.vpn == ctl.vpn));

  assign stat.hit   = hit_here;
  assign stat.first = hit_here & ~seen_in;
  assign stat.seen  = seen_in | hit_here;

  // A move to front shifts every cell up to the first match down by one;
  // a delete pulls every cell from the first match onward up by one.
  always_comb begin
    case (ctl.op)
      CELL_MTF: entry_next = seen_in ? entry : prev_entry;
      CELL_DEL: entry_next = (seen_in | hit_here) ? next_entry : entry;
      default:  entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

[sv/lru_translation_buffer.sv]
// Channel    Handshake         Payload
// request    start / busy      mode, pid, vpn, fill_frame
// result     done (strobe)     hit, found_frame, hit_count, miss_count
// config     cfg_we            cfg_wdata (max_entries)
//
// Every transaction first captures the request into registers; the cell row
// then compares and shifts while busy, and the result strobe follows.
// Invalidate process removes one matching entry per cycle, so its compare
// phase repeats until no matching entry is left beyond the one being removed.
// Reset is synchronous and leaves the buffer empty with max_entries at 16.
// The receiver cannot stall; busy alone holds off new requests.
`default_nettype none
`include "lru_translation_buffer_assert.svh"
module lru_translation_buffer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrutb_pkg::MODE_W-1:0]  mode,
  input  logic [lrutb_pkg::PID_W-1:0]   pid,
  input  logic [lrutb_pkg::VPN_W-1:0]   vpn,
  input  logic [lrutb_pkg::FRAME_W-1:0] fill_frame,
  input  logic                          cfg_we,
  input  logic [lrutb_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                          done,
  output logic                          hit,
  output logic [lrutb_pkg::FRAME_W-1:0] found_frame,
  output logic [lrutb_pkg::COUNT_W-1:0] hit_count,
  output logic [lrutb_pkg::COUNT_W-1:0] miss_count
);
  import lrutb_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [MODE_W-1:0]  mode_q;
  logic [PID_W-1:0]   pid_q;
  logic [VPN_W-1:0]   vpn_q;
  logic [FRAME_W-1:0] fill_q;
  logic [CFG_W-1:0]   max_entries;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   used_next;

  logic               accept;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   used_less;
  logic               drop;
  logic               found;
  logic               more;
  logic               finish;
  logic [FRAME_W-1:0] hit_frame;
  ctl_t               ctl;
  entry_t             head;

  entry_t             entries [DEPTH];
  entry_t             prev_e  [DEPTH];
  entry_t             next_e  [DEPTH];
  stat_t              stats   [DEPTH];
  logic [DEPTH-1:0]   seen_in;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   hit_vec;
  logic [DEPTH-1:0]   first_vec;

  assign accept = start & ~busy;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g]       = used > CNT_W'(g);
    assign hit_vec[g]   = stats[g].hit;
    assign first_vec[g] = stats[g].first;
    if (g == 0) begin : g_head
      assign prev_e[g]  = head;
      assign seen_in[g] = 1'b0;
    end else begin : g_body
      assign prev_e[g]  = entries[g-1];
      assign seen_in[g] = stats[g-1].seen;
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_e[g] = entries[g];
    end else begin : g_mid
      assign next_e[g] = entries[g+1];
    end
    lrutb_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[g]),
      .seen_in    (seen_in[g]),
      .prev_entry (prev_e[g]),
      .next_entry (next_e[g]),
      .entry      (entries[g]),
      .stat       (stats[g])
    );
  end

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        hit_frame = hit_frame | entries[i].frame;
      end
    end
  end

  assign found     = |first_vec;
  assign more      = |(hit_vec & ~first_vec);
  assign limit     = (max_entries > DEPTH_CNT) ? DEPTH_CNT : max_entries;
  assign used_less = used - CNT_W'(found);
  assign drop      = (used_less >= limit) && (used_less != '0);

  always_comb begin
    ctl.op       = CELL_HOLD;
    ctl.pid_only = 1'b0;
    ctl.pid      = pid_q;
    ctl.vpn      = vpn_q;
    head.pid     = pid_q;
    head.vpn     = vpn_q;
    head.frame   = hit_frame;
    used_next    = used;
    finish       = busy;
    case (mode_q)
      MODE_LOOKUP: begin
        ctl.op = found ? CELL_MTF : CELL_HOLD;
      end
      MODE_INSERT: begin
        head.frame = fill_q;
        if (limit != '0) begin
          ctl.op    = CELL_MTF;
          used_next = used_less - CNT_W'(drop) + CNT_W'(1'b1);
        end else begin
          ctl.op    = found ? CELL_DEL : CELL_HOLD;
          used_next = used_less - CNT_W'(drop);
        end
      end
      MODE_INV: begin
        ctl.op    = found ? CELL_DEL : CELL_HOLD;
        used_next = used_less;
      end
      MODE_INV_PROC: begin
        ctl.pid_only = 1'b1;
        ctl.op       = found ? CELL_DEL : CELL_HOLD;
        used_next    = used_less;
        finish       = busy & ~more;
      end
      MODE_FLUSH: begin
        used_next = '0;
      end
      default: begin
        used_next = used;
      end
    endcase
    if (!busy) begin
      ctl.op    = CELL_HOLD;
      used_next = used;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      pid_q  <= pid;
      vpn_q  <= vpn;
      fill_q <= fill_frame;
    end
    if (finish) begin
      hit         <= (mode_q == MODE_LOOKUP) && found;
      found_frame <= ((mode_q == MODE_LOOKUP) && found) ? hit_frame : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      used        <= '0;
      max_entries <= MAX_ENTRIES_RST;
      hit_count   <= '0;
      miss_count  <= '0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      used <= used_next;
      done <= finish;
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish && (mode_q == MODE_LOOKUP)) begin
        if (found) begin
          hit_count <= hit_count + COUNT_W'(1);
        end else begin
          miss_count <= miss_count + COUNT_W'(1);
        end
      end
    end
  end

  `LRUTB_ASSERT(a_used_max, clk, rst, used <= DEPTH_CNT, "occupancy above buffer depth")
  `LRUTB_ASSERT(a_one_first, clk, rst, $onehot0(first_vec), "more than one first match")
  `LRUTB_ASSERT(a_done_ends, clk, rst, done |-> (!busy && $past(busy)), "strobe without a transaction")
  `LRUTB_ASSERT_NORST(a_rst_idle, clk, (!rst && $past(rst)) |-> (!busy && !done), "not idle after reset")

endmodule
`default_nettype wire

[tb/lru_translation_buffer_tb.sv]
`default_nettype none
module lru_translation_buffer_tb;
  import lrutb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 105;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
  } lookup_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [MODE_W-1:0]  mode = MODE_LOOKUP;
  logic [PID_W-1:0]   pid = '0;
  logic [VPN_W-1:0]   vpn = '0;
  logic [FRAME_W-1:0] fill_frame = '0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               done;
  logic               hit;
  logic [FRAME_W-1:0] found_frame;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;

  lru_translation_buffer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .pid(pid), .vpn(vpn), .fill_frame(fill_frame),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .hit(hit), .found_frame(found_frame),
    .hit_count(hit_count), .miss_count(miss_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Translation state kept in recency order, most recently used at index 0.
  entry_t             lru_entries[$];
  logic [CFG_W-1:0]   size_limit = MAX_ENTRIES_RST;
  logic [COUNT_W-1:0] hits_total = '0;
  logic [COUNT_W-1:0] misses_total = '0;
  lookup_result_t     pending_results[$];
  lookup_result_t     oldest_result;
  int                 mismatch_count = 0;
  int                 stall_cycles = 0;
  logic [PID_W-1:0]   pid_pool[4];
  logic [VPN_W-1:0]   vpn_pool[6];

  function automatic void apply_translation(input logic [MODE_W-1:0] m,
                                            input logic [PID_W-1:0] p,
                                            input logic [VPN_W-1:0] v,
                                            input logic [FRAME_W-1:0] f);
    int             idx;
    int             cap;
    entry_t         e;
    lookup_result_t r;
    idx = -1;
    foreach (lru_entries[i])
      if (idx < 0 && lru_entries[i].pid == p && lru_entries[i].vpn == v) idx = i;
    cap = (size_limit > DEPTH) ? DEPTH : int'(size_limit);
    r = '0;
    case (m)
      MODE_LOOKUP: begin
        if (idx >= 0) begin
          e = lru_entries[idx];
          lru_entries.delete(idx);
          lru_entries.insert(0, e);
          hits_total = hits_total + 1'b1;
          r.hit = 1'b1;
          r.frame = e.frame;
        end else begin
          misses_total = misses_total + 1'b1;
        end
      end
      MODE_INSERT: begin
        if (idx >= 0) lru_entries.delete(idx);
        if (lru_entries.size() >= cap && lru_entries.size() > 0)
          lru_entries.delete(lru_entries.size() - 1);
        if (cap > 0 && lru_entries.size() < DEPTH) begin
          e.pid = p;
          e.vpn = v;
          e.frame = f;
          lru_entries.insert(0, e);
        end
      end
      MODE_INV: begin
        if (idx >= 0) lru_entries.delete(idx);
      end
      MODE_INV_PROC: begin
        for (int i = lru_entries.size() - 1; i >= 0; i--)
          if (lru_entries[i].pid == p) lru_entries.delete(i);
      end
      MODE_FLUSH: begin
        lru_entries.delete();
      end
      default: begin
      end
    endcase
    r.hits = hits_total;
    r.misses = misses_total;
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic issue_request(input logic [MODE_W-1:0] m, input logic [PID_W-1:0] p,
                               input logic [VPN_W-1:0] v, input logic [FRAME_W-1:0] f);
    start <= 1'b1;
    mode <= m;
    pid <= p;
    vpn <= v;
    fill_frame <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_translation(m, p, v, f);
  endtask

  task automatic hold_requests(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_results_clear;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_entries(input logic [CFG_W-1:0] value);
    wait_results_clear();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_limit = value;
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < REPORT_LIMIT)
          $display("[%0t] unexpected result: hit=%0b frame=%h hits=%0d misses=%0d",
                   $realtime, hit, found_frame, hit_count, miss_count);
      end else begin
        oldest_result = pending_results.pop_front();
        if (hit !== oldest_result.hit || found_frame !== oldest_result.frame ||
            hit_count !== oldest_result.hits || miss_count !== oldest_result.misses) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_LIMIT)
            $display("[%0t] mismatch: hit %0b/%0b frame %h/%h hits %0d/%0d misses %0d/%0d",
                     $realtime, oldest_result.hit, hit, oldest_result.frame, found_frame,
                     oldest_result.hits, hit_count, oldest_result.misses, miss_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** lru_translation_buffer: FAILED **");
      $finish;
    end
  end

  task automatic test_basic_modes;
    issue_request(MODE_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
    issue_request(MODE_INSERT, 16'h0000, 20'h00000, 20'hFFFFF);
    issue_request(MODE_INSERT, 16'hFFFF, 20'hFFFFF, 20'h00000);
    issue_request(MODE_INSERT, 16'hFFFF, 20'h00000, 20'h12345);
    issue_request(MODE_LOOKUP, 16'h0000, 20'h00000, 20'hFFFFF);
    issue_request(MODE_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0000, 20'hFFFFF, 20'h00000);
    issue_request(MODE_INSERT, 16'h0000, 20'h00000, 20'hAAAAA);
    issue_request(MODE_LOOKUP, 16'h0000, 20'h00000, 20'h55555);
    issue_request(MODE_INV, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    issue_request(MODE_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000);
    issue_request(MODE_INV, 16'h1234, 20'h54321, 20'h00000);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
      issue_request(m[MODE_W-1:0], 16'hFFFF, 20'h00000, 20'hFFFFF);
    issue_request(MODE_LOOKUP, 16'hFFFF, 20'h00000, 20'h00000);
    issue_request(MODE_INV_PROC, 16'hFFFF, 20'hFFFFF, 20'h00000);
    issue_request(MODE_LOOKUP, 16'hFFFF, 20'h00000, 20'h00000);
    issue_request(MODE_FLUSH, 16'h0000, 20'h00000, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
  endtask

  task automatic test_size_limits;
    set_max_entries(5'd16);
    for (int i = 0; i < 3; i++)
      issue_request(MODE_INSERT, 16'h0010, 20'(i), 20'(i + 1));
    set_max_entries(5'd0);
    issue_request(MODE_INSERT, 16'h0010, 20'd100, 20'hABCDE);
    issue_request(MODE_LOOKUP, 16'h0010, 20'd0, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0010, 20'd2, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0010, 20'd100, 20'h00000);
    set_max_entries(5'd1);
    issue_request(MODE_INSERT, 16'h0020, 20'd1, 20'h11111);
    issue_request(MODE_INSERT, 16'h0020, 20'd2, 20'h22222);
    issue_request(MODE_LOOKUP, 16'h0020, 20'd1, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0020, 20'd2, 20'h00000);
    set_max_entries(5'd31);
    issue_request(MODE_FLUSH, 16'h0000, 20'h00000, 20'h00000);
    for (int i = 0; i <= DEPTH; i++)
      issue_request(MODE_INSERT, 16'h0030, 20'(i), 20'($urandom));
    issue_request(MODE_LOOKUP, 16'h0030, 20'd0, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0030, 20'd1, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0030, 20'(DEPTH), 20'h00000);
    // Shrinking below the current fill: each insert evicts only one entry.
    set_max_entries(5'd4);
    issue_request(MODE_INSERT, 16'h0040, 20'd0, 20'h44444);
    issue_request(MODE_LOOKUP, 16'h0030, 20'd2, 20'h00000);
    issue_request(MODE_LOOKUP, 16'h0030, 20'd3, 20'h00000);
    issue_request(MODE_INSERT, 16'h0040, 20'd1, 20'h44445);
    set_max_entries(5'd16);
    issue_request(MODE_FLUSH, 16'h0000, 20'h00000, 20'h00000);
    for (int i = 0; i < DEPTH; i++)
      issue_request(MODE_INSERT, 16'hBEEF, 20'(i * 3), 20'($urandom));
    issue_request(MODE_INV_PROC, 16'hBEEF, 20'h00000, 20'h00000);
    issue_request(MODE_LOOKUP, 16'hBEEF, 20'd3, 20'h00000);
  endtask

  task automatic test_random_traffic;
    logic [CFG_W-1:0]  limit_choice;
    logic [MODE_W-1:0] m;
    logic [PID_W-1:0]  p;
    logic [VPN_W-1:0]  v;
    int                roll;
    bit                idling;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0: limit_choice = 5'd0;
        1: limit_choice = 5'd1;
        2: limit_choice = 5'd31;
        3: limit_choice = 5'd16;
        4: limit_choice = 5'd17;
        default: limit_choice = 5'($urandom_range(2, 15));
      endcase
      set_max_entries(limit_choice);
      foreach (pid_pool[i]) pid_pool[i] = 16'($urandom);
      foreach (vpn_pool[i]) vpn_pool[i] = 20'($urandom);
      idling = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 2) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) m = MODE_LOOKUP;
        else if (roll < 80) m = MODE_INSERT;
        else if (roll < 89) m = MODE_INV;
        else if (roll < 94) m = MODE_INV_PROC;
        else if (roll < 97) m = MODE_FLUSH;
        else m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pid_pool[$urandom_range(0, 3)];
        v = ($urandom_range(0, 9) == 0) ? 20'($urandom) : vpn_pool[$urandom_range(0, 5)];
        issue_request(m, p, v, 20'($urandom));
        if (phase == RANDOM_PHASES / 2 && n == PHASE_ITEMS / 2) wait_results_clear();
        else if (idling && $urandom_range(0, 99) < 20) hold_requests($urandom_range(1, 9));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_modes();
    test_size_limits();
    test_random_traffic();
    wait_results_clear();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** lru_translation_buffer: PASSED **");
    end else begin
      $display("** lru_translation_buffer: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/lrutb_pkg.sv
sv/lrutb_cell.sv
sv/lru_translation_buffer.sv
tb/lru_translation_buffer_tb.sv
